/* rtl/bvr_pkg.sv */
`default_nettype none
package bvr_pkg;

    // Fixed-point formats
    localparam int QUAT_FRAC_BITS = 14;
    localparam int VEL_FRAC_BITS  = 16;
    localparam int MAT_FRAC       = 28;
    localparam int MAT_W          = 30;
    localparam int QUAT_W         = 16;
    localparam int VEL_W          = 24;
    localparam int OUT_W          = 32;
    localparam int WGT_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Quaternion-to-matrix scaling
    localparam int RAW_W    = (2 * QUAT_FRAC_BITS + 3 > 36) ? 2 * QUAT_FRAC_BITS + 3 : 36;
    localparam int MAT_SHL  = (2 * QUAT_FRAC_BITS < MAT_FRAC) ? MAT_FRAC - 2 * QUAT_FRAC_BITS : 0;
    localparam int MAT_SHR  = (2 * QUAT_FRAC_BITS > MAT_FRAC) ? 2 * QUAT_FRAC_BITS - MAT_FRAC : 0;
    localparam int MAT_HALF = (2 ** MAT_SHR) / 2;
    localparam int MV_W     = RAW_W + MAT_SHL + 1;

    // Velocity Jacobian scaling
    localparam int JV_SHIFT = 2 * MAT_FRAC - VEL_FRAC_BITS;
    localparam int B_W      = 64 - JV_SHIFT;

    // Pipeline word widths
    localparam int PV_W = MAT_W + VEL_W;   // matrix entry times velocity
    localparam int PM_W = MAT_W + OUT_W;   // matrix entry times rotated velocity
    localparam int PB_W = 2 * MAT_W;       // matrix entry times matrix entry
    localparam int E_W  = OUT_W + 2;
    localparam int A_W  = 35;
    localparam int WP_W = 54;

    localparam logic signed [63:0] MAT_MAX = 64'sd536870911;
    localparam logic signed [63:0] MAT_MIN = -64'sd536870912;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXT_QW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_QX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_QY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_QZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WGT_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WGT_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WGT_Z  = 3'd6;

    // Row codes
    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic [WGT_W-1:0] x;
        logic [WGT_W-1:0] y;
        logic [WGT_W-1:0] z;
    } t_wgt;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [VEL_W-1:0]  world_vel_x;
        logic signed [VEL_W-1:0]  world_vel_y;
        logic signed [VEL_W-1:0]  world_vel_z;
        logic signed [VEL_W-1:0]  meas_vel_x;
        logic signed [VEL_W-1:0]  meas_vel_y;
        logic signed [VEL_W-1:0]  meas_vel_z;
    } t_in;

    typedef struct packed {
        logic [1:0]              row_index;
        logic signed [OUT_W-1:0] residual;
        logic signed [OUT_W-1:0] jac_rot_a;
        logic signed [OUT_W-1:0] jac_rot_b;
        logic signed [OUT_W-1:0] jac_rot_c;
        logic signed [OUT_W-1:0] jac_vel_a;
        logic signed [OUT_W-1:0] jac_vel_b;
        logic signed [OUT_W-1:0] jac_vel_c;
        logic                    last_row;
    } t_out;

    typedef logic signed [MAT_W-1:0] t_mat [3][3];
    typedef logic signed [OUT_W-1:0] t_vec32 [3];
    typedef logic signed [VEL_W-1:0] t_vel [3];

    // Round half up: floor((x + 2^(s-1)) / 2^s)
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] x, input int s);
        logic signed [63:0] half;
        half = (64'sd1 <<< s) >>> 1;
        return (x + half) >>> s;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [OUT_W-1:0] r;
        if (x > S32_MAX) begin
            r = S32_MAX[OUT_W-1:0];
        end else if (x < S32_MIN) begin
            r = S32_MIN[OUT_W-1:0];
        end else begin
            r = x[OUT_W-1:0];
        end
        return r;
    endfunction

    // Scale a raw product sum to Q2.28 and clamp to the matrix range
    function automatic logic signed [MAT_W-1:0] to_mat(input logic signed [RAW_W-1:0] raw);
        logic signed [MV_W-1:0] v;
        logic signed [63:0]     c;
        v = MV_W'(raw) <<< MAT_SHL;
        v = (v + MV_W'(MAT_HALF)) >>> MAT_SHR;
        c = 64'(v);
        if (c > MAT_MAX) begin
            c = MAT_MAX;
        end else if (c < MAT_MIN) begin
            c = MAT_MIN;
        end
        return c[MAT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/bvr_quat_mat.sv */
`default_nettype none
module bvr_quat_mat
    import bvr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en1,
    input  wire logic  i_en2,
    input  wire t_quat i_q,
    output t_mat       o_mat
);

    localparam logic signed [RAW_W-1:0] ONE = RAW_W'(1) <<< (2 * QUAT_FRAC_BITS);

    logic signed [31:0] r_xw, r_yw, r_zw, r_xx, r_xy, r_xz, r_yy, r_yz, r_zz;
    t_mat               r_mat;
    t_mat               n_mat;

    // Stage 1: quaternion component products
    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_xw <= 32'(i_q.x) * 32'(i_q.w);
            r_yw <= 32'(i_q.y) * 32'(i_q.w);
            r_zw <= 32'(i_q.z) * 32'(i_q.w);
            r_xx <= 32'(i_q.x) * 32'(i_q.x);
            r_xy <= 32'(i_q.x) * 32'(i_q.y);
            r_xz <= 32'(i_q.x) * 32'(i_q.z);
            r_yy <= 32'(i_q.y) * 32'(i_q.y);
            r_yz <= 32'(i_q.y) * 32'(i_q.z);
            r_zz <= 32'(i_q.z) * 32'(i_q.z);
        end
    end

    // Stage 2: matrix entries, scaled and clamped
    always_comb begin
        n_mat[0][0] = to_mat(ONE - ((RAW_W'(r_yy) + RAW_W'(r_zz)) <<< 1));
        n_mat[0][1] = to_mat((RAW_W'(r_xy) - RAW_W'(r_zw)) <<< 1);
        n_mat[0][2] = to_mat((RAW_W'(r_xz) + RAW_W'(r_yw)) <<< 1);
        n_mat[1][0] = to_mat((RAW_W'(r_xy) + RAW_W'(r_zw)) <<< 1);
        n_mat[1][1] = to_mat(ONE - ((RAW_W'(r_xx) + RAW_W'(r_zz)) <<< 1));
        n_mat[1][2] = to_mat((RAW_W'(r_yz) - RAW_W'(r_xw)) <<< 1);
        n_mat[2][0] = to_mat((RAW_W'(r_xz) - RAW_W'(r_yw)) <<< 1);
        n_mat[2][1] = to_mat((RAW_W'(r_yz) + RAW_W'(r_xw)) <<< 1);
        n_mat[2][2] = to_mat(ONE - ((RAW_W'(r_xx) + RAW_W'(r_yy)) <<< 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_mat <= n_mat;
        end
    end

    assign o_mat = r_mat;

endmodule
`default_nettype wire

/* rtl/bvr_row_unit.sv */
`default_nettype none
module bvr_row_unit
    import bvr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_mat   i_rb,
    input  wire t_vec32 i_vs,
    input  wire t_vel   i_vm,
    input  wire t_mat   i_ext,
    input  wire t_wgt   i_wgt,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out        o_data
);

    // Stage 0: item buffer, issues one row per cycle while stage 1 is ready
    logic       r_v0;
    logic [1:0] r_row;
    t_mat       r_rb;
    t_vec32     r_vs;
    t_vel       r_vm;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic iss_take;

    assign rdy4     = !r_v4 || i_ready;
    assign rdy3     = !r_v3 || rdy4;
    assign rdy2     = !r_v2 || rdy3;
    assign rdy1     = !r_v1 || rdy2;
    assign iss_take = r_v0 && rdy1;
    assign o_ready  = !r_v0 || (rdy1 && (r_row == ROW_Z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_row <= ROW_X;
        end else if (i_valid && o_ready) begin
            r_v0  <= 1'b1;
            r_row <= ROW_X;
        end else if (iss_take) begin
            if (r_row == ROW_Z) begin
                r_v0 <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rb <= i_rb;
            r_vs <= i_vs;
            r_vm <= i_vm;
        end
    end

    // Stage 1: row products of M (transposed extrinsic) with v_S and R
    logic signed [MAT_W-1:0] mrow [3];
    logic signed [PM_W-1:0]  r_pm [3][3];
    logic signed [PB_W-1:0]  r_pb [3][3];
    logic signed [VEL_W-1:0] r_vm1;
    logic [1:0]              r_row1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mrow[k] = i_ext[k][r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r_pm[k][l] <= PM_W'(mrow[k]) * PM_W'(r_vs[l]);
                    r_pb[k][l] <= PB_W'(mrow[l]) * PB_W'(r_rb[k][l]);
                end
            end
            r_vm1  <= r_vm[r_row];
            r_row1 <= r_row;
        end
    end

    // Stage 2: sums and rounding to error, A and B
    logic signed [63:0]      s_vp;
    logic signed [OUT_W-1:0] vp;
    logic signed [63:0]      s_a [3];
    logic signed [63:0]      s_b [3];
    logic signed [E_W-1:0]   r_e;
    logic signed [A_W-1:0]   r_a [3];
    logic signed [B_W-1:0]   r_b [3];
    logic [1:0]              r_row2;

    always_comb begin
        s_vp   = rnd_sh(64'(r_pm[0][0]) + 64'(r_pm[1][1]) + 64'(r_pm[2][2]), MAT_FRAC);
        vp     = sat32(s_vp);
        s_a[0] = rnd_sh(64'(r_pm[1][2]) - 64'(r_pm[2][1]), MAT_FRAC);
        s_a[1] = rnd_sh(64'(r_pm[2][0]) - 64'(r_pm[0][2]), MAT_FRAC);
        s_a[2] = rnd_sh(64'(r_pm[0][1]) - 64'(r_pm[1][0]), MAT_FRAC);
        for (int j = 0; j < 3; j++) begin
            s_b[j] = rnd_sh(64'(r_pb[j][0]) + 64'(r_pb[j][1]) + 64'(r_pb[j][2]), JV_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_e <= E_W'(r_vm1) - E_W'(vp);
            for (int j = 0; j < 3; j++) begin
                r_a[j] <= s_a[j][A_W-1:0];
                r_b[j] <= s_b[j][B_W-1:0];
            end
            r_row2 <= r_row1;
        end
    end

    // Stage 3: weighting, Jacobians negated
    logic [WGT_W-1:0]       wsel;
    logic signed [WGT_W:0]  wgt;
    logic signed [WP_W-1:0] r_we;
    logic signed [WP_W-1:0] r_wa [3];
    logic signed [WP_W-1:0] r_wb [3];
    logic [1:0]             r_row3;

    always_comb begin
        case (r_row2)
            ROW_X:   wsel = i_wgt.x;
            ROW_Y:   wsel = i_wgt.y;
            ROW_Z:   wsel = i_wgt.z;
            default: wsel = i_wgt.z;
        endcase
        wgt = $signed({1'b0, wsel});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_we <= WP_W'(wgt) * WP_W'(r_e);
            for (int j = 0; j < 3; j++) begin
                r_wa[j] <= -(WP_W'(wgt) * WP_W'(r_a[j]));
                r_wb[j] <= -(WP_W'(wgt) * WP_W'(r_b[j]));
            end
            r_row3 <= r_row2;
        end
    end

    // Stage 4: output register, drop the Q8.8 weight scale and saturate
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_out.row_index <= r_row3;
            r_out.residual  <= sat32(rnd_sh(64'(r_we), 8));
            r_out.jac_rot_a <= sat32(rnd_sh(64'(r_wa[0]), 8));
            r_out.jac_rot_b <= sat32(rnd_sh(64'(r_wa[1]), 8));
            r_out.jac_rot_c <= sat32(rnd_sh(64'(r_wa[2]), 8));
            r_out.jac_vel_a <= sat32(rnd_sh(64'(r_wb[0]), 8));
            r_out.jac_vel_b <= sat32(rnd_sh(64'(r_wb[1]), 8));
            r_out.jac_vel_c <= sat32(rnd_sh(64'(r_wb[2]), 8));
            r_out.last_row  <= (r_row3 == ROW_Z);
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* rtl/body_velocity_residual_jacobian.sv */
// Velocity measurement residual with rotation and velocity Jacobians.
// Input channel (i_valid/o_ready, i_data): one request carries the body
// quaternion, world velocity and measured sensor-frame velocity.
// Output channel (o_valid/i_ready, o_data): each request yields three rows
// (x, y, z) in order, last_row set on the z row.
// Config port (i_cfg_we/i_cfg_idx/i_cfg_data): extrinsic quaternion and
// per-axis weights. The user must write them only while the block is idle;
// the block itself does not enforce this. Unknown indexes are ignored.
// An accepted request passes the front stages and then the row unit; the x
// row leaves first, and the y and z rows follow on the next cycles when the
// receiver takes them. The row issue stage sets the request rate: it feeds
// one row per cycle, unless stalled, into the shared row datapath.
// Reset clears all valid bits and loads the register defaults (identity
// extrinsic, unit weights). A receiver stall holds each full stage whose
// later stages are full; the input is accepted while free stages remain.
`default_nettype none
module body_velocity_residual_jacobian
    import bvr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in                   i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out                       o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    t_quat r_ext;
    t_wgt  r_wgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext.w <= 16'sd16384;
            r_ext.x <= '0;
            r_ext.y <= '0;
            r_ext.z <= '0;
            r_wgt.x <= 16'd256;
            r_wgt.y <= 16'd256;
            r_wgt.z <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXT_QW: r_ext.w <= i_cfg_data;
                REG_EXT_QX: r_ext.x <= i_cfg_data;
                REG_EXT_QY: r_ext.y <= i_cfg_data;
                REG_EXT_QZ: r_ext.z <= i_cfg_data;
                REG_WGT_X:  r_wgt.x <= i_cfg_data;
                REG_WGT_Y:  r_wgt.y <= i_cfg_data;
                REG_WGT_Z:  r_wgt.z <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Extrinsic matrix, recomputed continuously from the registers
    t_mat ext_mat;

    bvr_quat_mat u_ext_mat (
        .i_clk (i_clk),
        .i_en1 (1'b1),
        .i_en2 (1'b1),
        .i_q   (r_ext),
        .o_mat (ext_mat)
    );

    // Front pipeline handshake
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic row_rdy;

    assign rdy4    = !r_v4 || row_rdy;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stages 1-2: body rotation matrix
    t_quat q_body;
    t_mat  rb;
    t_in   r_d1, r_d2, r_d3, r_d4;

    assign q_body = '{w: i_data.quat_w, x: i_data.quat_x, y: i_data.quat_y, z: i_data.quat_z};

    bvr_quat_mat u_body_mat (
        .i_clk (i_clk),
        .i_en1 (rdy1),
        .i_en2 (rdy2),
        .i_q   (q_body),
        .o_mat (rb)
    );

    always_ff @(posedge i_clk) begin
        if (rdy1) r_d1 <= i_data;
        if (rdy2) r_d2 <= r_d1;
        if (rdy3) r_d3 <= r_d2;
        if (rdy4) r_d4 <= r_d3;
    end

    // Stage 3: products R[k][i] * v_W[k]
    logic signed [VEL_W-1:0] vw [3];
    logic signed [PV_W-1:0]  r_pv [3][3];
    t_mat                    r_rb3, r_rb4;

    assign vw[0] = r_d2.world_vel_x;
    assign vw[1] = r_d2.world_vel_y;
    assign vw[2] = r_d2.world_vel_z;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pv[k][i] <= PV_W'(rb[k][i]) * PV_W'(vw[k]);
                end
            end
            r_rb3 <= rb;
        end
    end

    // Stage 4: v_S = R^T v_W, rounded and saturated
    t_vec32 r_vs;
    t_vel   vm;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            for (int i = 0; i < 3; i++) begin
                r_vs[i] <= sat32(rnd_sh(64'(r_pv[0][i]) + 64'(r_pv[1][i]) + 64'(r_pv[2][i]),
                                        MAT_FRAC));
            end
            r_rb4 <= r_rb3;
        end
    end

    assign vm[0] = r_d4.meas_vel_x;
    assign vm[1] = r_d4.meas_vel_y;
    assign vm[2] = r_d4.meas_vel_z;

    // Per-row residual and Jacobians
    bvr_row_unit u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (row_rdy),
        .i_rb    (r_rb4),
        .i_vs    (r_vs),
        .i_vm    (vm),
        .i_ext   (ext_mat),
        .i_wgt   (r_wgt),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Rows of one request leave back to back, in x, y, z order
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_row) |=>
        (o_valid && (o_data.row_index == $past(o_data.row_index) + 2'd1)))
        else $error("row sequence broken");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.last_row == (o_data.row_index == ROW_Z)) &&
                     (o_data.row_index <= ROW_Z)))
        else $error("last_row does not match row_index");

endmodule
`default_nettype wire
